[design/assert_macros.svh]
// Assertion helpers used by the parser unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CHK_SAME(label, ck, rn, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
		else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CHK_NEXT(label, ck, rn, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[design/hrlp_pkg.sv]
package hrlp_pkg;

	localparam int MAX_REQUEST_BYTES = 4096;
	localparam int POS_W = $clog2(MAX_REQUEST_BYTES + 1);
	localparam int OFFSET_W = 12;
	localparam int LENGTH_W = 13;

	localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_REQUEST_BYTES);
	localparam logic [POS_W-1:0] METHOD_LEN = POS_W'(3);
	localparam logic [POS_W-1:0] VERSION_LEN = POS_W'(8);

	typedef enum logic [1:0] {
		TOK_METHOD  = 2'd0,
		TOK_FILE    = 2'd1,
		TOK_VERSION = 2'd2,
		TOK_DONE    = 2'd3
	} token_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_request;
	} hrlp_in_t;

	typedef struct packed {
		logic                bad_request;
		logic                method_ok;
		logic                version_ok;
		logic [OFFSET_W-1:0] file_offset;
		logic [LENGTH_W-1:0] file_length;
		logic                too_long;
	} hrlp_out_t;

	function automatic logic [7:0] method_char(input logic [1:0] idx);
		logic [7:0] c;
		case (idx)
			2'd0: c = "G";
			2'd1: c = "E";
			2'd2: c = "T";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] version_char(input logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0: c = "H";
			3'd1: c = "T";
			3'd2: c = "T";
			3'd3: c = "P";
			3'd4: c = "/";
			3'd5: c = "1";
			3'd6: c = ".";
			default: c = "1";
		endcase
		return c;
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return (c == " ") || ((c >= 8'h09) && (c <= 8'h0D));
	endfunction

endpackage

[design/hrlp_core.sv]
module hrlp_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  hrlp_pkg::hrlp_in_t  item,
	output hrlp_pkg::hrlp_out_t result
);

	hrlp_pkg::token_t tn_q, tn_n;
	logic [hrlp_pkg::POS_W-1:0]    pos_q, pos_n;
	logic [hrlp_pkg::POS_W-1:0]    tl_q, tl_n;
	logic                          mm_q, mm_n;
	logic                          vm_q, vm_n;
	logic [hrlp_pkg::OFFSET_W-1:0] fs_q, fs_n;
	logic [hrlp_pkg::POS_W-1:0]    fsz_q, fsz_n;
	logic                          ov_q, ov_n;

	logic                          m_ok, v_ok;
	logic [hrlp_pkg::OFFSET_W-1:0] f_off;
	logic [hrlp_pkg::POS_W-1:0]    f_len;

	always_comb begin
		tn_n = tn_q;
		pos_n = pos_q;
		tl_n = tl_q;
		mm_n = mm_q;
		vm_n = vm_q;
		fs_n = fs_q;
		fsz_n = fsz_q;
		ov_n = ov_q;
		if (pos_q >= hrlp_pkg::MAX_POS) begin
			ov_n = 1'b1;
		end else begin
			pos_n = pos_q + hrlp_pkg::POS_W'(1);
			if (tn_q != hrlp_pkg::TOK_DONE) begin
				if (hrlp_pkg::is_blank(item.data_byte)) begin
					unique case (tn_q)
						hrlp_pkg::TOK_METHOD: begin
							if (tl_q != hrlp_pkg::METHOD_LEN) mm_n = 1'b0;
							tn_n = hrlp_pkg::TOK_FILE;
							fs_n = pos_n[hrlp_pkg::OFFSET_W-1:0];
						end
						hrlp_pkg::TOK_FILE: begin
							fsz_n = tl_q;
							tn_n = hrlp_pkg::TOK_VERSION;
						end
						hrlp_pkg::TOK_VERSION: begin
							if (tl_q != hrlp_pkg::VERSION_LEN) vm_n = 1'b0;
							tn_n = hrlp_pkg::TOK_DONE;
						end
						default: begin
							tn_n = tn_q;
						end
					endcase
					tl_n = '0;
				end else begin
					if (tn_q == hrlp_pkg::TOK_METHOD) begin
						if (tl_q >= hrlp_pkg::METHOD_LEN ||
							item.data_byte != hrlp_pkg::method_char(tl_q[1:0])) mm_n = 1'b0;
					end else if (tn_q == hrlp_pkg::TOK_VERSION) begin
						if (tl_q >= hrlp_pkg::VERSION_LEN ||
							item.data_byte != hrlp_pkg::version_char(tl_q[2:0])) vm_n = 1'b0;
					end
					if (tl_q < hrlp_pkg::MAX_POS) tl_n = tl_q + hrlp_pkg::POS_W'(1);
				end
			end
		end
	end

	always_comb begin
		m_ok = mm_n;
		v_ok = vm_n;
		f_off = fs_n;
		f_len = fsz_n;
		case (tn_n)
			hrlp_pkg::TOK_METHOD: begin
				m_ok = mm_n && (tl_n == hrlp_pkg::METHOD_LEN);
				v_ok = 1'b0;
				f_off = '0;
				f_len = '0;
			end
			hrlp_pkg::TOK_FILE: begin
				f_len = tl_n;
				v_ok = 1'b0;
			end
			hrlp_pkg::TOK_VERSION: begin
				v_ok = vm_n && (tl_n == hrlp_pkg::VERSION_LEN);
			end
			default: begin
				f_len = fsz_n;
			end
		endcase
		result.bad_request = !(m_ok && v_ok);
		result.method_ok = m_ok;
		result.version_ok = v_ok;
		result.file_offset = f_off;
		result.file_length = hrlp_pkg::LENGTH_W'(f_len);
		result.too_long = ov_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tn_q <= hrlp_pkg::TOK_METHOD;
			pos_q <= '0;
			tl_q <= '0;
			mm_q <= 1'b1;
			vm_q <= 1'b1;
			fs_q <= '0;
			fsz_q <= '0;
			ov_q <= 1'b0;
		end else if (step) begin
			if (item.end_of_request) begin
				tn_q <= hrlp_pkg::TOK_METHOD;
				pos_q <= '0;
				tl_q <= '0;
				mm_q <= 1'b1;
				vm_q <= 1'b1;
				fs_q <= '0;
				fsz_q <= '0;
				ov_q <= 1'b0;
			end else begin
				tn_q <= tn_n;
				pos_q <= pos_n;
				tl_q <= tl_n;
				mm_q <= mm_n;
				vm_q <= vm_n;
				fs_q <= fs_n;
				fsz_q <= fsz_n;
				ov_q <= ov_n;
			end
		end
	end

endmodule

[design/http_request_line_parser_unit.sv]
// HTTP request line parser.
// The req channel carries one byte of the request per transfer, with
// end_of_request set on the last byte. The parser splits the method, file
// and version tokens, checks the method against GET and the version against
// HTTP/1.1, and tracks the offset and length of the file token.
// The res channel carries one result per request, produced by the transfer
// of its last byte. Bytes past the size limit are not parsed and set too_long.
// Each accepted byte is held in an input register; from there the
// parser state is updated and, on a last byte, the result is written to the
// output register. The result thus passes the input register, then the output
// register, and one byte can be accepted in every cycle while req_stall is low.
// When the receiver stalls a pending result, non-final bytes still flow; only
// a last byte waits in the input register, and req_stall is raised until the
// output register is free again.
// Reset clears the parser state, the input valid and the output valid,
// so the next byte accepted starts a new request.
module http_request_line_parser_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  hrlp_pkg::hrlp_in_t  req_data,
	output logic                res_valid,
	input  logic                res_stall,
	output hrlp_pkg::hrlp_out_t res_data
);

	`include "assert_macros.svh"

	logic                valid_s1;
	hrlp_pkg::hrlp_in_t  item_s1;
	logic                res_valid_q;
	hrlp_pkg::hrlp_out_t res_data_q;
	hrlp_pkg::hrlp_out_t result;
	logic                out_free;
	logic                advance;

	assign out_free = !res_valid_q || !res_stall;
	assign advance = valid_s1 && (!item_s1.end_of_request || out_free);
	assign req_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			item_s1 <= req_data;
		end
	end

	hrlp_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && item_s1.end_of_request) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && item_s1.end_of_request) begin
			res_data_q <= result;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data = res_data_q;

	`CHK_SAME(a_err_consistent, clk, arst_n, res_valid, res_data.bad_request == !(res_data.method_ok && res_data.version_ok))
	`CHK_SAME(a_mid_byte_flows, clk, arst_n, valid_s1 && !item_s1.end_of_request, !req_stall)
	`CHK_SAME(a_result_from_last, clk, arst_n, $rose(res_valid), $past(valid_s1 && item_s1.end_of_request))

endmodule

[sim/http_request_line_parser_unit_tb.sv]
module http_request_line_parser_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned WATCHDOG_LIMIT = 3000;
	localparam int unsigned RANDOM_BYTES = 1350;
	localparam logic [7:0] CR = 8'h0D;
	localparam logic [7:0] LF = 8'h0A;
	localparam logic [0:2][7:0] GET_TEXT = "GET";
	localparam logic [0:7][7:0] HTTP11_TEXT = "HTTP/1.1";

	typedef struct {
		hrlp_pkg::hrlp_in_t item;
		int unsigned        gap;
		bit                 drain;
		bit                 hold;
	} queued_byte_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                req_valid = 1'b0;
	logic                req_stall;
	hrlp_pkg::hrlp_in_t  req_data = '0;
	logic                res_valid;
	logic                res_stall = 1'b0;
	hrlp_pkg::hrlp_out_t res_data;

	queued_byte_t        request_bytes_q[$];
	hrlp_pkg::hrlp_out_t awaited_parse_results[$];
	logic [7:0]          req_buf[$];

	int unsigned gap_limit = 0;
	bit          mark_drain = 1'b0;
	bit          mark_hold = 1'b0;

	int unsigned bytes_offered = 0;
	int unsigned bytes_taken = 0;
	int unsigned sender_idle = 0;
	int unsigned results_taken = 0;
	int unsigned results_seen = 0;
	int unsigned hold_requests = 0;
	int unsigned holds_done = 0;
	int unsigned hold_left = 0;
	int unsigned stall_left = 0;
	int unsigned stall_mode = 0;
	int unsigned failures = 0;
	int unsigned clean_results = 0;
	int unsigned over_limit_results = 0;

	// Parser state mirrored for prediction.
	hrlp_pkg::token_t parse_tok;
	logic [12:0]      parse_pos;
	logic [12:0]      parse_len;
	logic [12:0]      file_begin;
	logic [12:0]      file_len;
	bit               meth_good;
	bit               ver_good;
	bit               over_limit;

	http_request_line_parser_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_data (req_data),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_data (res_data)
	);

	always #5 clk = ~clk;

	function automatic bit is_separator(input logic [7:0] c);
		return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
	endfunction

	function automatic void clear_parser();
		parse_tok = hrlp_pkg::TOK_METHOD;
		parse_pos = '0;
		parse_len = '0;
		file_begin = '0;
		file_len = '0;
		meth_good = 1'b1;
		ver_good = 1'b1;
		over_limit = 1'b0;
	endfunction

	task automatic track_request_byte(input hrlp_pkg::hrlp_in_t item);
		hrlp_pkg::hrlp_out_t r;
		bit                  m_ok;
		bit                  v_ok;
		logic [12:0]         f_off;
		logic [12:0]         f_len;
		logic [7:0]          c;
		c = item.data_byte;
		if (parse_pos >= hrlp_pkg::MAX_POS) begin
			over_limit = 1'b1;
		end else begin
			parse_pos = parse_pos + 13'd1;
			if (parse_tok != hrlp_pkg::TOK_DONE) begin
				if (is_separator(c)) begin
					if (parse_tok == hrlp_pkg::TOK_METHOD && parse_len != hrlp_pkg::METHOD_LEN)
						meth_good = 1'b0;
					else if (parse_tok == hrlp_pkg::TOK_FILE)
						file_len = parse_len;
					else if (parse_tok == hrlp_pkg::TOK_VERSION
							&& parse_len != hrlp_pkg::VERSION_LEN)
						ver_good = 1'b0;
					parse_tok = hrlp_pkg::token_t'(parse_tok + 2'd1);
					parse_len = '0;
					if (parse_tok == hrlp_pkg::TOK_FILE)
						file_begin = parse_pos;
				end else begin
					if (parse_tok == hrlp_pkg::TOK_METHOD) begin
						if (parse_len >= hrlp_pkg::METHOD_LEN
								|| c != GET_TEXT[parse_len[1:0]])
							meth_good = 1'b0;
					end else if (parse_tok == hrlp_pkg::TOK_VERSION) begin
						if (parse_len >= hrlp_pkg::VERSION_LEN
								|| c != HTTP11_TEXT[parse_len[2:0]])
							ver_good = 1'b0;
					end
					if (parse_len < hrlp_pkg::MAX_POS)
						parse_len = parse_len + 13'd1;
				end
			end
		end
		if (item.end_of_request) begin
			m_ok = meth_good;
			v_ok = ver_good;
			f_off = file_begin;
			f_len = file_len;
			case (parse_tok)
				hrlp_pkg::TOK_METHOD: begin
					m_ok = m_ok && (parse_len == hrlp_pkg::METHOD_LEN);
					v_ok = 1'b0;
					f_off = '0;
					f_len = '0;
				end
				hrlp_pkg::TOK_FILE: begin
					f_len = parse_len;
					v_ok = 1'b0;
				end
				hrlp_pkg::TOK_VERSION: begin
					v_ok = v_ok && (parse_len == hrlp_pkg::VERSION_LEN);
				end
				default: ;
			endcase
			r.bad_request = !(m_ok && v_ok);
			r.method_ok = m_ok;
			r.version_ok = v_ok;
			r.file_offset = f_off[11:0];
			r.file_length = f_len;
			r.too_long = over_limit;
			awaited_parse_results.push_back(r);
			clear_parser();
		end
	endtask

	function automatic logic [7:0] any_separator();
		int unsigned k;
		k = $urandom_range(5, 13);
		return (k < 9) ? 8'h20 : 8'(k);
	endfunction

	function automatic logic [7:0] any_token_byte();
		logic [7:0] b;
		b = 8'($urandom_range(33, 126));
		if ($urandom_range(0, 3) == 0) begin
			b = 8'($urandom_range(0, 255));
			while (is_separator(b))
				b = 8'($urandom_range(0, 255));
		end
		return b;
	endfunction

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			req_buf.push_back(s[i]);
	endtask

	task automatic add_word(input int unsigned n);
		repeat (n) req_buf.push_back(any_token_byte());
	endtask

	task automatic send_request();
		queued_byte_t q;
		for (int i = 0; i < req_buf.size(); i++) begin
			q.item.data_byte = req_buf[i];
			q.item.end_of_request = (i == req_buf.size() - 1);
			q.gap = (gap_limit == 0) ? 0 : $urandom_range(0, gap_limit);
			q.drain = mark_drain;
			q.hold = mark_hold;
			mark_drain = 1'b0;
			mark_hold = 1'b0;
			request_bytes_q.push_back(q);
		end
		req_buf.delete();
	endtask

	task automatic build_request();
		int unsigned cut;
		case ($urandom_range(0, 11))
			0: add_text("GE");
			1: add_text("GETS");
			2: add_text("get");
			3: add_word($urandom_range(0, 6));
			4: begin
				add_text("GET");
				req_buf[$urandom_range(0, 2)] = any_token_byte();
			end
			default: add_text("GET");
		endcase
		req_buf.push_back(any_separator());
		if ($urandom_range(0, 15) == 0)
			req_buf.push_back(any_separator());
		add_word($urandom_range(0, 14));
		req_buf.push_back(any_separator());
		if ($urandom_range(0, 15) == 0)
			req_buf.push_back(any_separator());
		case ($urandom_range(0, 11))
			0: add_text("HTTP/1.0");
			1: add_text("HTTP/1.11");
			2: add_text("HTTP/1.");
			3: add_word($urandom_range(0, 10));
			4: begin
				add_text("HTTP/1.1");
				req_buf[req_buf.size() - 1 - $urandom_range(0, 7)] = any_token_byte();
			end
			default: add_text("HTTP/1.1");
		endcase
		case ($urandom_range(0, 3))
			0: ;
			1: begin
				req_buf.push_back(CR);
				req_buf.push_back(LF);
			end
			2: repeat ($urandom_range(1, 8)) req_buf.push_back(8'($urandom_range(0, 255)));
			default: begin
				req_buf.push_back(any_separator());
				add_word($urandom_range(1, 5));
			end
		endcase
		if ($urandom_range(0, 7) == 0) begin
			cut = $urandom_range(1, req_buf.size() - 1);
			req_buf = req_buf[0:cut-1];
		end
	endtask

	// Sender: one byte on the bus at a time, with a per-byte gap before it.
	always @(negedge clk) begin
		queued_byte_t       head;
		logic               next_valid;
		hrlp_pkg::hrlp_in_t next_data;
		next_valid = req_valid;
		next_data = req_data;
		if (arst_n) begin
			if (req_valid && bytes_taken == bytes_offered)
				next_valid = 1'b0;
			if (!next_valid && request_bytes_q.size() != 0) begin
				head = request_bytes_q[0];
				if (head.drain && awaited_parse_results.size() != 0) begin
					sender_idle = 0;
				end else if (sender_idle < head.gap) begin
					sender_idle++;
				end else begin
					head = request_bytes_q.pop_front();
					next_valid = 1'b1;
					next_data = head.item;
					bytes_offered++;
					sender_idle = 0;
					if (head.hold)
						hold_requests++;
				end
			end
		end
		req_valid <= next_valid;
		req_data <= next_data;
	end

	// Receiver: a fresh stall draw after every result transfer, plus long hold-offs.
	always @(negedge clk) begin
		logic next_stall;
		next_stall = 1'b0;
		if (hold_requests != holds_done) begin
			holds_done = hold_requests;
			hold_left = HOLD_CYCLES;
		end
		if (results_seen != results_taken) begin
			results_seen = results_taken;
			if ($urandom_range(0, 39) == 0)
				stall_mode = $urandom_range(0, 2);
			case (stall_mode)
				0: stall_left = 0;
				1: stall_left = $urandom_range(0, 3);
				default: stall_left = $urandom_range(0, 18);
			endcase
		end
		if (hold_left != 0) begin
			hold_left--;
			next_stall = 1'b1;
		end else if (stall_left != 0) begin
			stall_left--;
			next_stall = 1'b1;
		end
		res_stall <= next_stall;
	end

	always @(posedge clk) begin
		hrlp_pkg::hrlp_out_t want;
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				results_taken++;
				if (res_data.too_long)
					over_limit_results++;
				if (!res_data.bad_request)
					clean_results++;
				if (awaited_parse_results.size() == 0) begin
					failures++;
					if (failures <= 10)
						$display("unexpected result %0d with nothing awaited", results_taken);
				end else begin
					want = awaited_parse_results.pop_front();
					if (want.bad_request !== res_data.bad_request
							|| want.method_ok !== res_data.method_ok
							|| want.version_ok !== res_data.version_ok
							|| want.file_offset !== res_data.file_offset
							|| want.file_length !== res_data.file_length
							|| want.too_long !== res_data.too_long) begin
						failures++;
						if (failures <= 10) begin
							$display("result %0d: expected err=%0b meth=%0b ver=%0b off=%0d len=%0d long=%0b",
								results_taken, want.bad_request, want.method_ok, want.version_ok,
								want.file_offset, want.file_length, want.too_long);
							$display("result %0d:   actual err=%0b meth=%0b ver=%0b off=%0d len=%0d long=%0b",
								results_taken, res_data.bad_request, res_data.method_ok,
								res_data.version_ok, res_data.file_offset, res_data.file_length,
								res_data.too_long);
						end
					end
				end
			end
			if (req_valid && !req_stall) begin
				bytes_taken++;
				track_request_byte(req_data);
			end
		end
	end

	initial begin
		int unsigned quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (res_valid && !res_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("timeout: no transfer for %0d cycles", quiet);
		$display("FAIL http_request_line_parser_unit");
		$finish;
	end

	initial begin
		int unsigned random_bytes;
		int unsigned n_req;
		clear_parser();

		gap_limit = 3;
		req_buf.push_back(8'h00);
		send_request();
		req_buf.push_back(8'hFF);
		send_request();
		add_text("GET");
		send_request();
		req_buf.push_back(8'h20);
		send_request();
		add_text("GET /x HTTP/1.1");
		send_request();
		add_text("GET  HTTP/1.1");
		req_buf.push_back(CR);
		req_buf.push_back(LF);
		send_request();
		add_text("GET /a");
		send_request();
		add_text("POST /a HTTP");
		send_request();
		add_text("GET /a");
		req_buf.push_back(8'h09);
		add_text("HTTP/1.1");
		req_buf.push_back(LF);
		add_text("X");
		send_request();

		random_bytes = 0;
		n_req = 0;
		while (random_bytes < RANDOM_BYTES) begin
			if (n_req % 6 == 0) begin
				case ($urandom_range(0, 2))
					0: gap_limit = 0;
					1: gap_limit = 3;
					default: gap_limit = 18;
				endcase
			end
			if (n_req == 12 || n_req == 45) begin
				mark_hold = 1'b1;
				gap_limit = 0;
			end
			if (n_req % 15 == 7)
				mark_drain = 1'b1;
			build_request();
			random_bytes += req_buf.size();
			send_request();
			n_req++;
		end

		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		while (request_bytes_q.size() != 0 || req_valid || awaited_parse_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (awaited_parse_results.size() != 0) begin
			failures += awaited_parse_results.size();
			$display("%0d results never arrived", awaited_parse_results.size());
		end
		$display("Checked %0d request results from %0d byte transfers: %0d fully valid, %0d too long.",
			results_taken, bytes_taken, clean_results, over_limit_results);
		$display("The receiver held off %0d times for %0d cycles while bytes kept coming.",
			holds_done, HOLD_CYCLES);
		if (failures == 0)
			$display("PASS http_request_line_parser_unit");
		else
			$display("FAIL http_request_line_parser_unit");
		$finish;
	end

endmodule
